FILE: rtl/clx_pkg.sv
// Package for the C subset lexer: token kind codes, scan modes, keyword tracking codes
// and byte class functions. It depends on nothing else.
package clx_pkg;

    // Token kinds as they leave on the result channel.
    localparam logic [3:0] K_EOF       = 4'd0;
    localparam logic [3:0] K_LPAREN    = 4'd1;
    localparam logic [3:0] K_RPAREN    = 4'd2;
    localparam logic [3:0] K_LBRACE    = 4'd3;
    localparam logic [3:0] K_RBRACE    = 4'd4;
    localparam logic [3:0] K_SEMICOLON = 4'd5;
    localparam logic [3:0] K_EQ        = 4'd6;
    localparam logic [3:0] K_NUMBER    = 4'd7;
    localparam logic [3:0] K_KW_INT    = 4'd8;
    localparam logic [3:0] K_KW_RETURN = 4'd9;
    localparam logic [3:0] K_IDENT     = 4'd10;
    localparam logic [3:0] K_BAD       = 4'd11;
    localparam logic [3:0] K_OPEN      = 4'd12;

    // Keyword prefix tracking: how much of "int" or "return" has been seen.
    localparam logic [3:0] KW_NONE   = 4'd0;
    localparam logic [3:0] KW_I      = 4'd1;
    localparam logic [3:0] KW_IN     = 4'd2;
    localparam logic [3:0] KW_INT    = 4'd3;
    localparam logic [3:0] KW_R      = 4'd4;
    localparam logic [3:0] KW_RE     = 4'd5;
    localparam logic [3:0] KW_RET    = 4'd6;
    localparam logic [3:0] KW_RETU   = 4'd7;
    localparam logic [3:0] KW_RETUR  = 4'd8;
    localparam logic [3:0] KW_RETURN = 4'd9;

    // Largest literal value; larger literals saturate here.
    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    // Byte codes the scanner looks for.
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_UNDER  = "_";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_EQ     = "=";

    // Scanner modes, one-hot.
    typedef enum logic [7:0] {
        M_IDLE       = 8'b0000_0001,
        M_IDENT      = 8'b0000_0010,
        M_NUMBER     = 8'b0000_0100,
        M_SLASH      = 8'b0000_1000,
        M_LINE       = 8'b0001_0000,
        M_BLOCK      = 8'b0010_0000,
        M_BLOCK_STAR = 8'b0100_0000,
        M_HALT       = 8'b1000_0000
    } t_mode;

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    // True for the bytes that form a token on their own.
    function automatic logic is_single(input logic [7:0] c);
        return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACE) ||
               (c == CH_RBRACE) || (c == CH_SEMI) || (c == CH_EQ);
    endfunction

    function automatic logic [3:0] single_kind(input logic [7:0] c);
        logic [3:0] k;
        k = K_EQ;
        case (c)
            CH_LPAREN: k = K_LPAREN;
            CH_RPAREN: k = K_RPAREN;
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_SEMI:   k = K_SEMICOLON;
            default:   k = K_EQ;
        endcase
        return k;
    endfunction

    function automatic logic [3:0] kw_first(input logic [7:0] c);
        logic [3:0] t;
        t = KW_NONE;
        if (c == "i") t = KW_I;
        else if (c == "r") t = KW_R;
        return t;
    endfunction

    // Advance the keyword tracker by one identifier byte.
    function automatic logic [3:0] kw_next(input logic [3:0] t, input logic [7:0] c);
        logic [3:0] n;
        n = KW_NONE;
        case (t)
            KW_I:     n = (c == "n") ? KW_IN     : KW_NONE;
            KW_IN:    n = (c == "t") ? KW_INT    : KW_NONE;
            KW_R:     n = (c == "e") ? KW_RE     : KW_NONE;
            KW_RE:    n = (c == "t") ? KW_RET    : KW_NONE;
            KW_RET:   n = (c == "u") ? KW_RETU   : KW_NONE;
            KW_RETU:  n = (c == "r") ? KW_RETUR  : KW_NONE;
            KW_RETUR: n = (c == "n") ? KW_RETURN : KW_NONE;
            default:  n = KW_NONE;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/clx_ifs.sv
// Valid/ready channel interfaces of the C subset lexer: source bytes in, tokens out.
// They depend on nothing else.
interface clx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_text;

    modport source (output valid, output ch, output end_of_text, input ready);
    modport sink   (input valid, input ch, input end_of_text, output ready);
endinterface

interface clx_tok_if #(
    parameter int POS_BITS    = 16,
    parameter int OFFSET_BITS = 24
);
    logic                   valid;
    logic                   ready;
    logic [3:0]             kind;
    logic [POS_BITS-1:0]    tok_line;
    logic [POS_BITS-1:0]    tok_column;
    logic [OFFSET_BITS-1:0] tok_offset;
    logic [POS_BITS-1:0]    tok_length;
    logic [30:0]            number_value;
    logic                   number_overflow;
    logic [7:0]             bad_byte;
    logic                   last_of_run;

    modport source (
        output valid, output kind, output tok_line, output tok_column, output tok_offset,
        output tok_length, output number_value, output number_overflow, output bad_byte,
        output last_of_run, input ready
    );
    modport sink (
        input valid, input kind, input tok_line, input tok_column, input tok_offset,
        input tok_length, input number_value, input number_overflow, input bad_byte,
        input last_of_run, output ready
    );
endinterface

FILE: rtl/c_subset_lexer.sv
// C subset lexer top level: input byte register, scanner core and token channel.
// Uses clx_pkg, the channel interfaces in clx_ifs and clx_core.
//
// Usage:
//   i_byte carries one source byte per word (ch) or an end-of-text mark
//   (end_of_text = 1, ch ignored). o_tok carries token words; a byte gives zero, one
//   or two words, and last_of_run marks the final word of a byte. End of text gives
//   any pending token or error, then EOF, and the lexer starts over at line 1.
//   A byte accepted into the input register is scanned from there, and its token words
//   are written into the token queue, from whose head they can be taken.
//   Throughput: one byte per cycle while the receiver keeps up. The scanner takes a
//   byte only while the four-word token queue has room for two words, so bytes that
//   give two tokens, or a stalled receiver, slow intake to the rate words leave.
//   A stalled receiver holds the head word steady; the input register and the queue
//   absorb the slack, then i_byte.ready drops. No byte or token is dropped.
//   Reset (i_rst_n low, synchronous) empties the queue and input register and puts
//   the scanner at line 1, column 0, offset 0.
module c_subset_lexer #(
    parameter int POS_BITS    = 16,
    parameter int OFFSET_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    clx_byte_if.sink   i_byte,
    clx_tok_if.source  o_tok
);
    import clx_pkg::*;

    logic       r_in_valid;
    logic       n_in_valid;
    logic [7:0] r_ch;
    logic       r_eot;
    logic       w_take;
    logic       w_accept;

    // The input register frees up in the same cycle the scanner takes its byte.
    assign i_byte.ready = !r_in_valid || w_take;
    assign w_accept     = i_byte.valid && i_byte.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) n_in_valid = 1'b1;
        else if (w_take) n_in_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch  <= i_byte.ch;
            r_eot <= i_byte.end_of_text;
        end
    end

    clx_core #(
        .POS_BITS    (POS_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_ch        (r_ch),
        .i_eot       (r_eot),
        .i_out_ready (o_tok.ready),
        .o_take      (w_take),
        .o_valid     (o_tok.valid),
        .o_kind      (o_tok.kind),
        .o_line      (o_tok.tok_line),
        .o_column    (o_tok.tok_column),
        .o_offset    (o_tok.tok_offset),
        .o_length    (o_tok.tok_length),
        .o_value     (o_tok.number_value),
        .o_overflow  (o_tok.number_overflow),
        .o_bad       (o_tok.bad_byte),
        .o_last      (o_tok.last_of_run)
    );

`ifndef ASSERT_OFF
    // A byte waiting in the input register is kept until the scanner takes it.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_take |=> r_in_valid && $stable(r_ch) && $stable(r_eot))
        else $error("input byte lost before scan");

    // EOF is always the final word of its byte.
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid && (o_tok.kind == K_EOF) |-> o_tok.last_of_run)
        else $error("EOF word without end-of-run flag");

    // A bad byte token is one byte long and lines count from one.
    a_bad_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tok.valid && (o_tok.kind == K_BAD) |->
            (o_tok.tok_length == POS_BITS'(1)) && (o_tok.tok_line != '0))
        else $error("malformed bad_char token");
`endif

endmodule

FILE: rtl/clx_fifo.sv
// Four-word token queue for the C subset lexer: takes up to two words per cycle in
// order and hands out one word per cycle from its head. It depends on nothing else.
module clx_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [1:0]   i_push_cnt,
    input  logic [W-1:0] i_data0,
    input  logic [W-1:0] i_data1,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data,
    output logic         o_room2
);
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] n_wr;
    logic [AW-1:0] r_rd;
    logic [AW-1:0] n_rd;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          w_pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign o_room2 = (r_count <= CW'(DEPTH - 2));
    assign w_pop   = o_valid && i_pop;

    // Pointer and fill count update.
    always_comb begin
        n_wr    = r_wr + AW'(i_push_cnt);
        n_rd    = r_rd + AW'(w_pop);
        n_count = r_count + CW'(i_push_cnt) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Storage; the first word goes to the write pointer, the second right after it.
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_data0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wr + AW'(1)] <= i_data1;
        end
    end

endmodule

FILE: rtl/clx_core.sv
// Scanner of the C subset lexer: mode register, position counters, run accumulators and
// the token words of one byte, fed into the token queue. Uses clx_pkg and clx_fifo.
module clx_core #(
    parameter int POS_BITS    = 16,
    parameter int OFFSET_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_ch,
    input  logic                   i_eot,
    input  logic                   i_out_ready,
    output logic                   o_take,
    output logic                   o_valid,
    output logic [3:0]             o_kind,
    output logic [POS_BITS-1:0]    o_line,
    output logic [POS_BITS-1:0]    o_column,
    output logic [OFFSET_BITS-1:0] o_offset,
    output logic [POS_BITS-1:0]    o_length,
    output logic [30:0]            o_value,
    output logic                   o_overflow,
    output logic [7:0]             o_bad,
    output logic                   o_last
);
    import clx_pkg::*;

    typedef struct packed {
        logic [3:0]             kind;
        logic [POS_BITS-1:0]    line;
        logic [POS_BITS-1:0]    column;
        logic [OFFSET_BITS-1:0] offset;
        logic [POS_BITS-1:0]    length;
        logic [30:0]            value;
        logic                   overflow;
        logic [7:0]             bad;
        logic                   last;
    } t_tok;

    localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

    // Scan state.
    t_mode                  r_mode,   n_mode;
    logic [POS_BITS-1:0]    r_line,   n_line;
    logic [POS_BITS-1:0]    r_col,    n_col;
    logic [OFFSET_BITS-1:0] r_off,    n_off;
    logic [POS_BITS-1:0]    r_sline,  n_sline;
    logic [POS_BITS-1:0]    r_scol,   n_scol;
    logic [OFFSET_BITS-1:0] r_soff,   n_soff;
    logic [POS_BITS-1:0]    r_run,    n_run;
    logic [30:0]            r_acc,    n_acc;
    logic                   r_ovf,    n_ovf;
    logic [3:0]             r_kw,     n_kw;

    logic        w_room;
    logic        w_take;
    logic        w_do_idle;
    logic        w_va;
    logic        w_vb;
    t_tok        w_ta;
    t_tok        w_tb;
    t_tok        w_head;
    t_tok        w_flush;
    t_tok        w_slash;
    logic [34:0] w_acc10;
    logic [1:0]  w_push_cnt;
    t_tok        w_d0;

    assign w_take = i_valid && w_room;
    assign o_take = w_take;

    // Next literal value: acc * 10 + digit, wide enough to see the overflow.
    assign w_acc10 = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {31'b0, i_ch[3:0]};

    // Pending identifier or number as a token word.
    always_comb begin
        w_flush        = '0;
        w_flush.line   = r_sline;
        w_flush.column = r_scol;
        w_flush.offset = r_soff;
        w_flush.length = r_run;
        if (r_mode == M_NUMBER) begin
            w_flush.kind     = K_NUMBER;
            w_flush.value    = r_acc;
            w_flush.overflow = r_ovf;
        end else if (r_kw == KW_INT) begin
            w_flush.kind = K_KW_INT;
        end else if (r_kw == KW_RETURN) begin
            w_flush.kind = K_KW_RETURN;
        end else begin
            w_flush.kind = K_IDENT;
        end
    end

    // A slash that opened no comment, reported at its own position.
    always_comb begin
        w_slash        = '0;
        w_slash.kind   = K_BAD;
        w_slash.line   = r_sline;
        w_slash.column = r_scol;
        w_slash.offset = r_soff;
        w_slash.length = POS_ONE;
        w_slash.bad    = CH_SLASH;
    end

    // Mode step, token words and position update for one taken byte.
    always_comb begin
        n_mode    = r_mode;
        n_line    = r_line;
        n_col     = r_col;
        n_off     = r_off;
        n_sline   = r_sline;
        n_scol    = r_scol;
        n_soff    = r_soff;
        n_run     = r_run;
        n_acc     = r_acc;
        n_ovf     = r_ovf;
        n_kw      = r_kw;
        w_va      = 1'b0;
        w_vb      = 1'b0;
        w_ta      = '0;
        w_tb      = '0;
        w_do_idle = 1'b0;

        if (w_take && i_eot) begin
            // End of text: pending token or error, then EOF; back to the reset state.
            unique case (r_mode)
                M_IDENT, M_NUMBER: begin
                    w_va = 1'b1;
                    w_ta = w_flush;
                end
                M_SLASH: begin
                    w_va = 1'b1;
                    w_ta = w_slash;
                end
                M_BLOCK, M_BLOCK_STAR: begin
                    w_va        = 1'b1;
                    w_ta        = w_slash;
                    w_ta.kind   = K_OPEN;
                    w_ta.length = '0;
                    w_ta.bad    = '0;
                end
                M_IDLE, M_LINE, M_HALT: begin
                    w_va = 1'b0;
                end
                default: begin
                    w_va = 1'b0;
                end
            endcase
            w_vb        = 1'b1;
            w_tb.kind   = K_EOF;
            w_tb.line   = r_line;
            w_tb.column = r_col;
            w_tb.offset = r_off;
            n_mode      = M_IDLE;
            n_line      = POS_ONE;
            n_col       = '0;
            n_off       = '0;
            n_sline     = POS_ONE;
            n_scol      = '0;
            n_soff      = '0;
            n_run       = '0;
            n_acc       = '0;
            n_ovf       = 1'b0;
            n_kw        = KW_NONE;
        end else if (w_take) begin
            unique case (r_mode)
                M_HALT: begin
                    n_mode = M_HALT;
                end
                M_LINE: begin
                    if (i_ch == CH_NL) n_mode = M_IDLE;
                end
                M_BLOCK: begin
                    if (i_ch == CH_STAR) n_mode = M_BLOCK_STAR;
                end
                M_BLOCK_STAR: begin
                    if (i_ch == CH_SLASH) n_mode = M_IDLE;
                    else if (i_ch != CH_STAR) n_mode = M_BLOCK;
                end
                M_SLASH: begin
                    if (i_ch == CH_SLASH) begin
                        n_mode = M_LINE;
                    end else if (i_ch == CH_STAR) begin
                        n_mode = M_BLOCK;
                    end else begin
                        w_va   = 1'b1;
                        w_ta   = w_slash;
                        n_mode = M_HALT;
                    end
                end
                M_IDENT: begin
                    if (is_word(i_ch)) begin
                        if (r_run != '1) n_run = r_run + POS_ONE;
                        n_kw = kw_next(r_kw, i_ch);
                    end else begin
                        w_va      = 1'b1;
                        w_ta      = w_flush;
                        w_do_idle = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(i_ch)) begin
                        if (r_run != '1) n_run = r_run + POS_ONE;
                        if (w_acc10 > {4'b0, NUM_MAX}) begin
                            n_acc = NUM_MAX;
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = w_acc10[30:0];
                        end
                    end else begin
                        w_va      = 1'b1;
                        w_ta      = w_flush;
                        w_do_idle = 1'b1;
                    end
                end
                M_IDLE: begin
                    w_do_idle = 1'b1;
                end
                default: begin
                    w_do_idle = 1'b1;
                end
            endcase

            // Scan the byte as the first byte of a new token; its word goes second.
            if (w_do_idle) begin
                n_mode      = M_IDLE;
                w_tb.line   = r_line;
                w_tb.column = r_col;
                w_tb.offset = r_off;
                w_tb.length = POS_ONE;
                if (is_space(i_ch)) begin
                    w_vb = 1'b0;
                end else if (is_single(i_ch)) begin
                    w_vb      = 1'b1;
                    w_tb.kind = single_kind(i_ch);
                end else if (is_digit(i_ch)) begin
                    n_mode  = M_NUMBER;
                    n_sline = r_line;
                    n_scol  = r_col;
                    n_soff  = r_off;
                    n_run   = POS_ONE;
                    n_acc   = {27'b0, i_ch[3:0]};
                    n_ovf   = 1'b0;
                end else if (is_alpha(i_ch) || (i_ch == CH_UNDER)) begin
                    n_mode  = M_IDENT;
                    n_sline = r_line;
                    n_scol  = r_col;
                    n_soff  = r_off;
                    n_run   = POS_ONE;
                    n_kw    = kw_first(i_ch);
                end else if (i_ch == CH_SLASH) begin
                    n_mode  = M_SLASH;
                    n_sline = r_line;
                    n_scol  = r_col;
                    n_soff  = r_off;
                end else begin
                    w_vb      = 1'b1;
                    w_tb.kind = K_BAD;
                    w_tb.bad  = i_ch;
                    n_mode    = M_HALT;
                end
            end

            // Every byte moves the position, saturating.
            if (i_ch == CH_NL) begin
                if (r_line != '1) n_line = r_line + POS_ONE;
                n_col = '0;
            end else if (r_col != '1) begin
                n_col = r_col + POS_ONE;
            end
            if (r_off != '1) n_off = r_off + OFFSET_BITS'(1);
        end

        // Only the last word of a byte carries the end-of-run flag.
        w_ta.last = !w_vb;
        w_tb.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_line  <= POS_ONE;
            r_col   <= '0;
            r_off   <= '0;
            r_sline <= POS_ONE;
            r_scol  <= '0;
            r_soff  <= '0;
            r_run   <= '0;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_kw    <= KW_NONE;
        end else begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_col   <= n_col;
            r_off   <= n_off;
            r_sline <= n_sline;
            r_scol  <= n_scol;
            r_soff  <= n_soff;
            r_run   <= n_run;
            r_acc   <= n_acc;
            r_ovf   <= n_ovf;
            r_kw    <= n_kw;
        end
    end

    // Pack the words in order so the queue sees no gap.
    assign w_push_cnt = {1'b0, w_va} + {1'b0, w_vb};
    assign w_d0       = w_va ? w_ta : w_tb;

    clx_fifo #(
        .W($bits(t_tok))
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_data0    (w_d0),
        .i_data1    (w_tb),
        .i_pop      (i_out_ready),
        .o_valid    (o_valid),
        .o_data     (w_head),
        .o_room2    (w_room)
    );

    assign o_kind     = w_head.kind;
    assign o_line     = w_head.line;
    assign o_column   = w_head.column;
    assign o_offset   = w_head.offset;
    assign o_length   = w_head.length;
    assign o_value    = w_head.value;
    assign o_overflow = w_head.overflow;
    assign o_bad      = w_head.bad;
    assign o_last     = w_head.last;

endmodule
